>>> rtl/rsfh_pkg.sv
// Package with field widths, register codes and shared types for the ray-sphere first-hit block.
package rsfh_pkg;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int RSQ_W     = 63;
	localparam int DIST_W    = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(64'd4294967296);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_CENTER_Z       = 3'd2,
		REG_RADIUS_SQUARED = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [RSQ_W-1:0]          radius_squared;
	} sphere_cfg_t;

endpackage

>>> rtl/rsfh_ifs.sv
// Channel interfaces for rays, hit results and configuration writes.
interface rsfh_ray_if;
	logic valid;
	logic ready;
	logic signed [rsfh_pkg::COORD_W-1:0] origin_x;
	logic signed [rsfh_pkg::COORD_W-1:0] origin_y;
	logic signed [rsfh_pkg::COORD_W-1:0] origin_z;
	logic signed [rsfh_pkg::DIR_W-1:0]   dir_x;
	logic signed [rsfh_pkg::DIR_W-1:0]   dir_y;
	logic signed [rsfh_pkg::DIR_W-1:0]   dir_z;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rsfh_hit_if;
	logic valid;
	logic ready;
	logic hit;
	logic [rsfh_pkg::DIST_W-1:0] hit_distance;
	modport source(output valid, hit, hit_distance, input ready);
	modport sink(input valid, hit, hit_distance, output ready);
endinterface

interface rsfh_cfg_if;
	logic valid;
	logic ready;
	logic [rsfh_pkg::CFG_IDX_W-1:0] idx;
	logic [rsfh_pkg::CFG_DAT_W-1:0] data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

>>> rtl/rsfh_front.sv
// Front pipeline: offset to the centre, projection, squares and discriminant.
module rsfh_front #(
	parameter int FRAC_BITS = 16,
	parameter int PW        = 37,
	parameter int DISC_W    = 76
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsfh_pkg::sphere_cfg_t cfg,
	rsfh_ray_if.sink              ray,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_miss,
	output logic [DISC_W-2:0]     out_disc,
	output logic signed [PW-1:0]  out_p
);
	localparam int CW     = rsfh_pkg::COORD_W + 1;
	localparam int PROD_W = rsfh_pkg::DIR_W + CW;
	localparam int DOT_W  = PROD_W + 2;
	localparam int SQD_W  = 2 * CW;
	localparam int SUM_W  = SQD_W + 2;
	localparam int H      = (PW + 1) / 2;
	localparam int L      = PW - H;
	localparam int PSQ_W  = 2 * PW;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [CW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [rsfh_pkg::DIR_W-1:0] ux_s1, uy_s1, uz_s1;
	logic signed [PROD_W-1:0] mx_s2, my_s2, mz_s2;
	logic [SQD_W-1:0] qx_s2, qy_s2, qz_s2;
	logic signed [PW-1:0] p_s3, p_s4, p_s5, p_s6;
	logic [SUM_W-1:0] sum_s3, sum_s4, sum_s5;
	logic [2*H-1:0] ll_s4;
	logic [PW-1:0] lh_s4;
	logic [2*L-1:0] hh_s4;
	logic [PSQ_W-1:0] psq_s5;
	logic [DISC_W-1:0] disc_s6;

	logic [CW-1:0] ax, ay, az;
	logic signed [DOT_W-1:0] dot;
	logic [PW-1:0] pa;

	assign en = !v_s6 || out_ready;
	assign ray.ready = en;

	assign ax = dx_s1[CW-1] ? CW'(-dx_s1) : CW'(dx_s1);
	assign ay = dy_s1[CW-1] ? CW'(-dy_s1) : CW'(dy_s1);
	assign az = dz_s1[CW-1] ? CW'(-dz_s1) : CW'(dz_s1);
	assign dot = DOT_W'(mx_s2) + DOT_W'(my_s2) + DOT_W'(mz_s2);
	assign pa = p_s3[PW-1] ? PW'(-p_s3) : PW'(p_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= CW'(cfg.center_x) - CW'(ray.origin_x);
			dy_s1 <= CW'(cfg.center_y) - CW'(ray.origin_y);
			dz_s1 <= CW'(cfg.center_z) - CW'(ray.origin_z);
			ux_s1 <= ray.dir_x;
			uy_s1 <= ray.dir_y;
			uz_s1 <= ray.dir_z;

			mx_s2 <= PROD_W'(ux_s1) * PROD_W'(dx_s1);
			my_s2 <= PROD_W'(uy_s1) * PROD_W'(dy_s1);
			mz_s2 <= PROD_W'(uz_s1) * PROD_W'(dz_s1);
			qx_s2 <= SQD_W'(ax) * SQD_W'(ax);
			qy_s2 <= SQD_W'(ay) * SQD_W'(ay);
			qz_s2 <= SQD_W'(az) * SQD_W'(az);

			p_s3   <= PW'(dot >>> FRAC_BITS);
			sum_s3 <= SUM_W'(qx_s2) + SUM_W'(qy_s2) + SUM_W'(qz_s2);

			ll_s4  <= (2*H)'(pa[H-1:0]) * (2*H)'(pa[H-1:0]);
			lh_s4  <= PW'(pa[H-1:0]) * PW'(pa[PW-1:H]);
			hh_s4  <= (2*L)'(pa[PW-1:H]) * (2*L)'(pa[PW-1:H]);
			p_s4   <= p_s3;
			sum_s4 <= sum_s3;

			psq_s5 <= (PSQ_W'(hh_s4) << (2*H)) + (PSQ_W'(lh_s4) << (H+1)) + PSQ_W'(ll_s4);
			p_s5   <= p_s4;
			sum_s5 <= sum_s4;

			disc_s6 <= DISC_W'(cfg.radius_squared) + DISC_W'(psq_s5) - DISC_W'(sum_s5);
			p_s6    <= p_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_miss  = disc_s6[DISC_W-1];
	assign out_disc  = disc_s6[DISC_W-2:0];
	assign out_p     = p_s6;
endmodule

>>> rtl/rsfh_queue.sv
// Small queue that decouples the front pipeline from the square-root back end.
module rsfh_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end
endmodule

>>> rtl/rsfh_back.sv
// Back pipeline: one root bit per stage, then the near distance and the result register.
module rsfh_back #(
	parameter int PW     = 37,
	parameter int DISC_W = 76
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_miss,
	input  logic [DISC_W-2:0]    in_disc,
	input  logic signed [PW-1:0] in_p,
	rsfh_hit_if.source           res
);
	localparam int MW     = DISC_W - 1;
	localparam int ROOT_W = DISC_W / 2;
	localparam int TW     = ((PW > ROOT_W) ? PW : ROOT_W) + 2;
	localparam int DW     = rsfh_pkg::DIST_W;

	logic en;
	logic v_q [ROOT_W+1];
	logic miss_q [ROOT_W+1];
	logic [MW-1:0] val_q [ROOT_W+1];
	logic [MW-1:0] sq_q [ROOT_W+1];
	logic [ROOT_W-1:0] root_q [ROOT_W+1];
	logic signed [PW-1:0] p_q [ROOT_W+1];

	logic v_out_q, hit_q;
	logic [DW-1:0] dist_q;
	logic signed [TW-1:0] t;

	assign en = !v_out_q || res.ready;
	assign in_ready = en;

	assign v_q[0]    = in_valid;
	assign miss_q[0] = in_miss;
	assign val_q[0]  = in_disc;
	assign sq_q[0]   = '0;
	assign root_q[0] = '0;
	assign p_q[0]    = in_p;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic [MW+1:0] cand;
		assign cand = (MW+2)'(sq_q[k]) + ((MW+2)'(root_q[k]) << (B+1))
			+ ((MW+2)'(1) << (2*B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				miss_q[k+1] <= miss_q[k];
				val_q[k+1]  <= val_q[k];
				p_q[k+1]    <= p_q[k];
				if (cand <= (MW+2)'(val_q[k])) begin
					root_q[k+1] <= root_q[k] | (ROOT_W'(1) << B);
					sq_q[k+1]   <= MW'(cand);
				end else begin
					root_q[k+1] <= root_q[k];
					sq_q[k+1]   <= sq_q[k];
				end
			end
		end
	end

	assign t = TW'(p_q[ROOT_W]) - TW'({1'b0, root_q[ROOT_W]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_q[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (miss_q[ROOT_W] || t[TW-1]) begin
				hit_q  <= 1'b0;
				dist_q <= '0;
			end else begin
				hit_q  <= 1'b1;
				dist_q <= (|t[TW-2:DW]) ? '1 : t[DW-1:0];
			end
		end
	end

	assign res.valid        = v_out_q;
	assign res.hit          = hit_q;
	assign res.hit_distance = dist_q;
endmodule

>>> rtl/ray_sphere_first_hit.sv
// Top level of the ray-sphere first-hit block: configuration registers, front, queue and back.
//
//  channel  direction  payload                                   transaction
//  ray      in         origin_x/y/z, dir_x/y/z                   valid && ready
//  res      out        hit, hit_distance                         valid && ready
//  cfg      in         idx, data                                 valid && ready
//
// One ray is accepted per cycle while the front is not stalled; each gives one result after
// 6 front stages, the queue, DISC_W/2 square-root stages (one root bit each) and the result
// register. Reset clears all valid state and loads the register defaults. A stalled result
// holds the back end; the queue lets the front keep running until it fills.
module ray_sphere_first_hit #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rsfh_ray_if.sink   ray,
	rsfh_hit_if.source res,
	rsfh_cfg_if.sink   cfg
);
	localparam int DOT_W  = rsfh_pkg::DIR_W + rsfh_pkg::COORD_W + 3;
	localparam int PW     = DOT_W - FRAC_BITS;
	localparam int SUM_W  = 2 * (rsfh_pkg::COORD_W + 1) + 2;
	localparam int DISC_W = ((2 * PW > SUM_W) ? 2 * PW : SUM_W) + 2;
	localparam int QW     = 1 + (DISC_W - 1) + PW;

	rsfh_pkg::sphere_cfg_t cfg_q;

	logic f_valid, f_ready, f_miss;
	logic [DISC_W-2:0] f_disc;
	logic signed [PW-1:0] f_p;
	logic b_valid, b_ready;
	logic [QW-1:0] b_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.center_z       <= '0;
			cfg_q.radius_squared <= rsfh_pkg::RSQ_RESET;
		end else if (cfg.valid) begin
			case (cfg.idx)
				rsfh_pkg::REG_CENTER_X: cfg_q.center_x <= cfg.data[rsfh_pkg::COORD_W-1:0];
				rsfh_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg.data[rsfh_pkg::COORD_W-1:0];
				rsfh_pkg::REG_CENTER_Z: cfg_q.center_z <= cfg.data[rsfh_pkg::COORD_W-1:0];
				rsfh_pkg::REG_RADIUS_SQUARED:
					cfg_q.radius_squared <= cfg.data[rsfh_pkg::RSQ_W-1:0];
				default: ;
			endcase
		end
	end

	rsfh_front #(.FRAC_BITS(FRAC_BITS), .PW(PW), .DISC_W(DISC_W)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .ray(ray),
		.out_valid(f_valid), .out_ready(f_ready),
		.out_miss(f_miss), .out_disc(f_disc), .out_p(f_p)
	);

	rsfh_queue #(.W(QW), .DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data({f_miss, f_disc, f_p}),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	rsfh_back #(.PW(PW), .DISC_W(DISC_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready),
		.in_miss(b_data[QW-1]), .in_disc(b_data[QW-2:PW]), .in_p(b_data[PW-1:0]),
		.res(res)
	);
endmodule
